// File: design/mfs_pkg.sv
// Shared types, constants and the sigmoid table of the perceptron core.
package mfs_pkg;

  localparam int MAX_NEURONS_DEF = 16;
  localparam int VALUE_WIDTH_DEF = 16;
  localparam int FRAC_BITS       = 12;
  localparam int ACT_W           = 13;
  localparam int CNT_W           = 5;
  localparam int IDX_W           = 4;
  localparam int RESULT_CAP      = 16;
  localparam int CMD_DEPTH       = 4;
  localparam int CFG_IDX_W       = 2;
  localparam int SIG_SHIFT       = FRAC_BITS - 3;
  localparam int SIG_MID         = 64;
  localparam int SIG_LAST        = 128;

  localparam logic [1:0] OP_WEIGHT  = 2'd0;
  localparam logic [1:0] OP_BIAS    = 2'd1;
  localparam logic [1:0] OP_FEATURE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIDDEN_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_COUNT = 2'd2;

  localparam logic [CNT_W-1:0] INPUT_COUNT_RST  = 5'd4;
  localparam logic [CNT_W-1:0] HIDDEN_COUNT_RST = 5'd3;
  localparam logic [CNT_W-1:0] OUTPUT_COUNT_RST = 5'd2;

  typedef enum logic [2:0] {
    KIND_HW,
    KIND_OW,
    KIND_HB,
    KIND_OB,
    KIND_FEAT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic             wr_ok;
    logic             run;
    logic [IDX_W-1:0] nidx;
    logic [IDX_W-1:0] sidx;
  } cmd_ctl_t;

  typedef struct packed {
    logic [CNT_W-1:0] input_count;
    logic [CNT_W-1:0] hidden_count;
    logic [CNT_W-1:0] output_count;
  } cfg_regs_t;

  typedef struct packed {
    logic [IDX_W-1:0] neuron_number;
    logic [ACT_W-1:0] activation;
    logic             last_result;
  } result_t;

  localparam logic [ACT_W-1:0] SIG_TABLE [SIG_LAST+1] = '{
    13'd1, 13'd2, 13'd2, 13'd2, 13'd2, 13'd3, 13'd3, 13'd3,
    13'd4, 13'd4, 13'd5, 13'd5, 13'd6, 13'd7, 13'd8, 13'd9,
    13'd10, 13'd11, 13'd13, 13'd15, 13'd17, 13'd19, 13'd21, 13'd24,
    13'd27, 13'd31, 13'd35, 13'd40, 13'd45, 13'd51, 13'd58, 13'd65,
    13'd74, 13'd83, 13'd94, 13'd106, 13'd120, 13'd136, 13'd153, 13'd172,
    13'd194, 13'd219, 13'd246, 13'd277, 13'd311, 13'd349, 13'd391, 13'd437,
    13'd488, 13'd545, 13'd606, 13'd674, 13'd747, 13'd827, 13'd912, 13'd1004,
    13'd1102, 13'd1205, 13'd1314, 13'd1428, 13'd1546, 13'd1668, 13'd1793, 13'd1920,
    13'd2048, 13'd2176, 13'd2303, 13'd2428, 13'd2550, 13'd2668, 13'd2782, 13'd2891,
    13'd2994, 13'd3092, 13'd3184, 13'd3269, 13'd3349, 13'd3422, 13'd3490, 13'd3551,
    13'd3608, 13'd3659, 13'd3705, 13'd3747, 13'd3785, 13'd3819, 13'd3850, 13'd3877,
    13'd3902, 13'd3924, 13'd3943, 13'd3960, 13'd3976, 13'd3990, 13'd4002, 13'd4013,
    13'd4022, 13'd4031, 13'd4038, 13'd4045, 13'd4051, 13'd4056, 13'd4061, 13'd4065,
    13'd4069, 13'd4072, 13'd4075, 13'd4077, 13'd4079, 13'd4081, 13'd4083, 13'd4085,
    13'd4086, 13'd4087, 13'd4088, 13'd4089, 13'd4090, 13'd4091, 13'd4091, 13'd4092,
    13'd4092, 13'd4093, 13'd4093, 13'd4093, 13'd4094, 13'd4094, 13'd4094, 13'd4094,
    13'd4095
  };

endpackage

// File: design/mfs_fifo.sv
// Small register queue used between front and engine and for results.
module mfs_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem [DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_r];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= (wr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
      if (do_pop)  rd_r <= (rd_r == PTR_W'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
      if (do_push && !do_pop)      cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end
endmodule

// File: design/mfs_front.sv
// Input decoder: classifies words, checks index range, drops unused opcodes.
module mfs_front import mfs_pkg::*; #(
  parameter int MAX_NEURONS = MAX_NEURONS_DEF
) (
  input  logic             in_push,
  input  logic [1:0]       in_operation,
  input  logic             in_layer_select,
  input  logic [IDX_W-1:0] in_neuron_index,
  input  logic [IDX_W-1:0] in_source_index,
  input  logic             in_is_last,
  input  logic             q_full,
  output logic             in_full,
  output logic             q_push,
  output cmd_ctl_t         q_ctl
);
  logic n_ok, s_ok, known;

  assign n_ok    = int'(in_neuron_index) < MAX_NEURONS;
  assign s_ok    = int'(in_source_index) < MAX_NEURONS;
  assign in_full = q_full;
  assign q_push  = in_push && !q_full && known;

  always_comb begin
    q_ctl.nidx  = in_neuron_index;
    q_ctl.sidx  = in_source_index;
    q_ctl.run   = 1'b0;
    q_ctl.wr_ok = 1'b0;
    q_ctl.kind  = KIND_FEAT;
    known       = 1'b1;
    unique case (in_operation)
      OP_WEIGHT: begin
        q_ctl.kind  = in_layer_select ? KIND_OW : KIND_HW;
        q_ctl.wr_ok = n_ok && s_ok;
      end
      OP_BIAS: begin
        q_ctl.kind  = in_layer_select ? KIND_OB : KIND_HB;
        q_ctl.wr_ok = n_ok;
      end
      OP_FEATURE: begin
        q_ctl.wr_ok = s_ok;
        q_ctl.run   = in_is_last;
      end
      default: known = 1'b0;
    endcase
  end
endmodule

// File: design/mfs_engine.sv
// Back end: weight stores and the shared multiply-accumulate sequencer.
module mfs_engine import mfs_pkg::*; #(
  parameter int MAX_NEURONS = MAX_NEURONS_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cfg_regs_t              cfg,
  input  logic                   cmd_empty,
  input  cmd_ctl_t               cmd_ctl,
  input  logic [VALUE_WIDTH-1:0] cmd_value,
  output logic                   cmd_pop,
  input  logic                   res_full,
  output logic                   res_push,
  output result_t                res_data
);
  localparam int NW    = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1;
  localparam int AW    = $clog2(MAX_NEURONS * MAX_NEURONS);
  localparam int OPW   = (VALUE_WIDTH > ACT_W + 1) ? VALUE_WIDTH : ACT_W + 1;
  localparam int PW    = VALUE_WIDTH + OPW;
  localparam int SW    = PW + 1;
  localparam int OCAP  = (MAX_NEURONS < RESULT_CAP) ? MAX_NEURONS : RESULT_CAP;

  typedef enum logic [2:0] {
    ST_IDLE, ST_BRD, ST_BLD, ST_MUL, ST_ACC, ST_RD, ST_FIRE
  } state_t;

  logic signed [VALUE_WIDTH-1:0] hw_mem [MAX_NEURONS*MAX_NEURONS];
  logic signed [VALUE_WIDTH-1:0] ow_mem [MAX_NEURONS*MAX_NEURONS];
  logic signed [VALUE_WIDTH-1:0] hb_mem [MAX_NEURONS];
  logic signed [VALUE_WIDTH-1:0] ob_mem [MAX_NEURONS];
  logic signed [VALUE_WIDTH-1:0] ft_mem [MAX_NEURONS];
  logic        [ACT_W-1:0]       ha_mem [MAX_NEURONS];

  logic signed [VALUE_WIDTH-1:0] hw_q, ow_q, hb_q, ob_q, ft_q;
  logic        [ACT_W-1:0]       ha_q;

  state_t                  state_r;
  logic [CNT_W-1:0]        k_r, i_r;
  logic                    layer_r;
  logic signed [VALUE_WIDTH-1:0] sum_r;
  logic signed [PW-1:0]    prod_r;
  result_t                 res_r;
  logic                    res_push_r;

  logic [CNT_W-1:0] ni, hn, on, n_cur;
  logic [AW-1:0]    waddr, raddr;
  logic [NW-1:0]    kaddr, iaddr;
  logic             pop_go;
  logic signed [OPW-1:0] x_op;
  logic signed [VALUE_WIDTH-1:0] w_op;
  logic signed [SW-1:0] acc_wide;
  logic signed [VALUE_WIDTH-1:0] sum_sat;
  logic [ACT_W-1:0] act;
  int               sig_idx;

  function automatic logic [CNT_W-1:0] clamp_cnt(input logic [CNT_W-1:0] c, input int cap);
    logic [CNT_W-1:0] r;
    r = c;
    if (c == '0) r = CNT_W'(1);
    else if (int'(c) > cap) r = CNT_W'(cap);
    return r;
  endfunction

  assign ni    = clamp_cnt(cfg.input_count, MAX_NEURONS);
  assign hn    = clamp_cnt(cfg.hidden_count, MAX_NEURONS);
  assign on    = clamp_cnt(cfg.output_count, OCAP);
  assign n_cur = layer_r ? hn : ni;

  assign pop_go  = (state_r == ST_IDLE) && !cmd_empty;
  assign cmd_pop = pop_go;
  assign waddr   = AW'(int'(cmd_ctl.nidx) * MAX_NEURONS + int'(cmd_ctl.sidx));
  assign raddr   = AW'(int'(k_r) * MAX_NEURONS + int'(i_r));
  assign kaddr   = NW'(k_r);
  assign iaddr   = NW'(i_r);

  // Stores: writes come only from popped load/feature words.
  always_ff @(posedge clk) begin
    if (pop_go && cmd_ctl.wr_ok) begin
      unique case (cmd_ctl.kind)
        KIND_HW:   hw_mem[waddr] <= cmd_value;
        KIND_OW:   ow_mem[waddr] <= cmd_value;
        KIND_HB:   hb_mem[NW'(cmd_ctl.nidx)] <= cmd_value;
        KIND_OB:   ob_mem[NW'(cmd_ctl.nidx)] <= cmd_value;
        KIND_FEAT: ft_mem[NW'(cmd_ctl.sidx)] <= cmd_value;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FIRE && !layer_r) ha_mem[kaddr] <= act;
  end

  always_ff @(posedge clk) begin
    hw_q <= hw_mem[raddr];
    ow_q <= ow_mem[raddr];
    hb_q <= hb_mem[kaddr];
    ob_q <= ob_mem[kaddr];
    ft_q <= ft_mem[iaddr];
    ha_q <= ha_mem[iaddr];
  end

  always_comb begin
    w_op     = layer_r ? ow_q : hw_q;
    x_op     = layer_r ? OPW'($signed({1'b0, ha_q})) : OPW'(ft_q);
    acc_wide = SW'(sum_r) + SW'(prod_r >>> FRAC_BITS);
    // saturate when the top bits disagree with the sign
    if (acc_wide[SW-1:VALUE_WIDTH-1] == '0 || acc_wide[SW-1:VALUE_WIDTH-1] == '1)
      sum_sat = acc_wide[VALUE_WIDTH-1:0];
    else
      sum_sat = acc_wide[SW-1] ? {1'b1, {(VALUE_WIDTH-1){1'b0}}}
                               : {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    sig_idx = (int'(sum_r) >>> SIG_SHIFT) + SIG_MID;
    if (sig_idx < 0) sig_idx = 0;
    if (sig_idx > SIG_LAST) sig_idx = SIG_LAST;
    act = SIG_TABLE[8'(sig_idx)];
  end

  assign res_push = res_push_r;
  assign res_data = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      k_r        <= '0;
      i_r        <= '0;
      layer_r    <= 1'b0;
      res_push_r <= 1'b0;
    end else begin
      res_push_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (pop_go && cmd_ctl.kind == KIND_FEAT && cmd_ctl.run) begin
            k_r     <= '0;
            i_r     <= '0;
            layer_r <= 1'b0;
            state_r <= ST_BRD;
          end
        end
        ST_BRD: state_r <= ST_BLD;
        ST_BLD: begin
          sum_r   <= layer_r ? ob_q : hb_q;
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          prod_r  <= w_op * x_op;
          state_r <= ST_ACC;
        end
        ST_ACC: begin
          sum_r <= sum_sat;
          if (CNT_W'(i_r + 1'b1) == n_cur) begin
            state_r <= ST_FIRE;
          end else begin
            i_r     <= i_r + 1'b1;
            state_r <= ST_RD;
          end
        end
        ST_RD: state_r <= ST_MUL;
        ST_FIRE: begin
          if (!layer_r) begin
            i_r     <= '0;
            state_r <= ST_BRD;
            if (CNT_W'(k_r + 1'b1) == hn) begin
              k_r     <= '0;
              layer_r <= 1'b1;
            end else begin
              k_r <= k_r + 1'b1;
            end
          end else if (!res_full && !res_push_r) begin
            // never push in the cycle after a push, so the full flag is current
            res_push_r            <= 1'b1;
            res_r.neuron_number   <= IDX_W'(k_r);
            res_r.activation      <= act;
            res_r.last_result     <= (CNT_W'(k_r + 1'b1) == on);
            i_r                   <= '0;
            if (CNT_W'(k_r + 1'b1) == on) begin
              state_r <= ST_IDLE;
            end else begin
              k_r     <= k_r + 1'b1;
              state_r <= ST_BRD;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end
endmodule

// File: design/mlp_forward_sigmoid_core.sv
// Top level of the two-layer perceptron core with table sigmoid.
//
//  channel | handshake           | payload
//  --------+---------------------+--------------------------------------------
//  in_     | in_push / in_full   | operation, layer_select, neuron/source index,
//          |                     | value, is_last
//  out_    | out_pop / out_empty | neuron_number, activation, last_result
//  cfg_    | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// Load and feature words pass through a four-word queue, which the engine
// pops only while idle. A run's length is set by the single shared
// multiply-accumulate stepping through the weight memories.
// Results go into a 16-word queue; when it fills the engine holds.
// Reset empties the queues, clears the engine counters and loads the default
// layer counts; weight, bias and feature stores are undefined until written.
module mlp_forward_sigmoid_core import mfs_pkg::*; #(
  parameter int MAX_NEURONS = MAX_NEURONS_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_push,
  output logic                   in_full,
  input  logic [1:0]             in_operation,
  input  logic                   in_layer_select,
  input  logic [IDX_W-1:0]       in_neuron_index,
  input  logic [IDX_W-1:0]       in_source_index,
  input  logic [VALUE_WIDTH-1:0] in_value,
  input  logic                   in_is_last,
  output logic                   out_empty,
  input  logic                   out_pop,
  output logic [IDX_W-1:0]       out_neuron_number,
  output logic [ACT_W-1:0]       out_activation,
  output logic                   out_last_result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CNT_W-1:0]       cfg_data
);
  localparam int CW = $bits(cmd_ctl_t) + VALUE_WIDTH;

  cfg_regs_t cfg_r;
  cmd_ctl_t  fr_ctl, q_ctl;
  logic      fr_push, q_full, q_empty, q_pop;
  logic [VALUE_WIDTH-1:0] q_value;
  logic [CW-1:0] q_rdata;
  logic      res_full, res_push;
  result_t   res_wdata, res_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.input_count  <= INPUT_COUNT_RST;
      cfg_r.hidden_count <= HIDDEN_COUNT_RST;
      cfg_r.output_count <= OUTPUT_COUNT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_INPUT_COUNT:  cfg_r.input_count  <= cfg_data;
        CFG_HIDDEN_COUNT: cfg_r.hidden_count <= cfg_data;
        CFG_OUTPUT_COUNT: cfg_r.output_count <= cfg_data;
        default: ;
      endcase
    end
  end

  mfs_front #(.MAX_NEURONS(MAX_NEURONS)) u_front (
    .in_push         (in_push),
    .in_operation    (in_operation),
    .in_layer_select (in_layer_select),
    .in_neuron_index (in_neuron_index),
    .in_source_index (in_source_index),
    .in_is_last      (in_is_last),
    .q_full          (q_full),
    .in_full         (in_full),
    .q_push          (fr_push),
    .q_ctl           (fr_ctl)
  );

  mfs_fifo #(.W(CW), .DEPTH(CMD_DEPTH)) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fr_push),
    .wdata ({fr_ctl, in_value}),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign q_ctl   = q_rdata[CW-1:VALUE_WIDTH];
  assign q_value = q_rdata[VALUE_WIDTH-1:0];

  mfs_engine #(.MAX_NEURONS(MAX_NEURONS), .VALUE_WIDTH(VALUE_WIDTH)) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_empty (q_empty),
    .cmd_ctl   (q_ctl),
    .cmd_value (q_value),
    .cmd_pop   (q_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_wdata)
  );

  mfs_fifo #(.W($bits(result_t)), .DEPTH(RESULT_CAP)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_wdata),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_rdata),
    .empty (out_empty)
  );

  assign out_neuron_number = res_rdata.neuron_number;
  assign out_activation    = res_rdata.activation;
  assign out_last_result   = res_rdata.last_result;
endmodule

// File: design/mfs_checker.sv
// Port-level checker for the perceptron core, bound to the top level.
module mfs_checker import mfs_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             out_empty,
  input logic             out_pop,
  input logic [IDX_W-1:0] out_neuron_number,
  input logic [ACT_W-1:0] out_activation,
  input logic             out_last_result
);
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  a_act_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_activation <= 13'd4096)
    else $error("activation above one");

  a_in_order: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_pop && !out_last_result) |=>
      (out_empty || out_neuron_number == IDX_W'($past(out_neuron_number) + 1'b1)))
    else $error("result word out of order");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_activation)))
    else $error("stalled result word changed");
endmodule

bind mlp_forward_sigmoid_core mfs_checker u_mfs_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_empty         (out_empty),
  .out_pop           (out_pop),
  .out_neuron_number (out_neuron_number),
  .out_activation    (out_activation),
  .out_last_result   (out_last_result)
);
